// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion macros, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// File: src/uetu_pkg.sv
// ---------------------------------------------------------------------------
// uetu_pkg
// Shared types and constants of the escape-to-UTF-8 decoder.
// ---------------------------------------------------------------------------
package uetu_pkg;

	localparam int MaxResults = 4;
	localparam int CntW       = $clog2(MaxResults + 1);
	localparam int IdxW       = $clog2(MaxResults);

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic [MaxResults-1:0][7:0] bytes;
		logic                       bad;
		logic [CntW-1:0]            cnt;
		logic                       eos;
	} res_bundle_t;

endpackage

// File: src/uetu_decode.sv
// ---------------------------------------------------------------------------
// uetu_decode
// Escape state and single-pass decode of one byte into its result bundle.
// ---------------------------------------------------------------------------
module uetu_decode
	import uetu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  byte_t       in_byte,
	input  logic        in_eos,
	input  logic        advance,
	output res_bundle_t res
);

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_BSL  = 3'd1,
		PH_HEX0 = 3'd2,
		PH_HEX1 = 3'd3,
		PH_HEX2 = 3'd4,
		PH_HEX3 = 3'd5
	} phase_t;

	localparam byte_t ChBsl = 8'h5C;
	localparam byte_t ChU   = 8'h75;

	function automatic logic [4:0] hex_nib(input byte_t c);
		logic [4:0] r;
		r = 5'b0;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	function automatic logic [16:0] absorb(input logic [15:0] hv, input logic stp,
		input byte_t c);
		logic [4:0]  h;
		logic [16:0] r;
		h = hex_nib(c);
		r = {stp, hv};
		if (!stp) begin
			if (h[4]) r = {1'b0, hv[11:0], h[3:0]};
			else r = {1'b1, hv};
		end
		return r;
	endfunction

	phase_t      phase_q, phase_d;
	logic [15:0] hv_q, hv_d;
	logic        stop_q, stop_d;
	byte_t       held_q [3];
	logic        held_we;
	logic [1:0]  j;
	logic [16:0] abs_r;
	logic [15:0] v;
	logic [4:0]  nib0;
	logic [3:0][7:0] t;
	logic [3:0]  keep;
	logic [2:0]  len;
	logic [2:0]  oi;

	assign j     = 2'(3'(phase_q) - 3'(PH_HEX0));
	assign abs_r = absorb(hv_q, stop_q, in_byte);
	assign v     = abs_r[15:0];
	assign nib0  = hex_nib(held_q[0]);

	always_comb begin
		t[0] = ChU;
		for (int k = 1; k < 4; k++) begin
			t[k] = (2'(k - 1) < j) ? held_q[k-1] : in_byte;
		end
		len = 3'(j) + 3'd2;
		for (int k = 0; k < 4; k++) begin
			keep[k] = (3'(k) < len) &&
				!(t[k] == ChBsl && (3'(k + 1) < len) && t[(k + 1) % 4] == ChU);
		end
	end

	always_comb begin
		res     = '0;
		res.eos = in_eos;
		phase_d = phase_q;
		hv_d    = hv_q;
		stop_d  = stop_q;
		held_we = 1'b0;
		oi      = 3'd0;
		unique case (phase_q) inside
			PH_BSL: begin
				if (in_byte == ChU) begin
					hv_d   = 16'd0;
					stop_d = 1'b0;
					if (in_eos) begin
						res.bytes[0] = ChU;
						res.cnt      = CntW'(1);
						phase_d      = PH_IDLE;
					end else begin
						phase_d = PH_HEX0;
					end
				end else begin
					res.bytes[0] = ChBsl;
					if (in_byte == ChBsl && !in_eos) begin
						res.cnt = CntW'(1);
						phase_d = PH_BSL;
					end else begin
						res.bytes[1] = in_byte;
						res.cnt      = CntW'(2);
						phase_d      = PH_IDLE;
					end
				end
			end
			PH_HEX0, PH_HEX1, PH_HEX2: begin
				if (in_eos) begin
					for (int k = 0; k < 4; k++) begin
						if (keep[k]) begin
							res.bytes[oi[1:0]] = t[k];
							oi = oi + 3'd1;
						end
					end
					res.cnt = CntW'(oi);
					phase_d = PH_IDLE;
				end else begin
					held_we = 1'b1;
					hv_d    = abs_r[15:0];
					stop_d  = abs_r[16];
					phase_d = phase_t'(3'(phase_q) + 3'd1);
				end
			end
			PH_HEX3: begin
				hv_d   = abs_r[15:0];
				stop_d = abs_r[16];
				if (!nib0[4]) begin
					res.bad = 1'b1;
					res.cnt = CntW'(1);
				end else if (v <= 16'h007F) begin
					res.bytes[0] = v[7:0];
					res.cnt      = CntW'(1);
				end else if (v <= 16'h07FF) begin
					res.bytes[0] = 8'hC0 | {3'b0, v[10:6]};
					res.bytes[1] = 8'h80 | {2'b0, v[5:0]};
					res.cnt      = CntW'(2);
				end else begin
					res.bytes[0] = 8'hE0 | {4'b0, v[15:12]};
					res.bytes[1] = 8'h80 | {2'b0, v[11:6]};
					res.bytes[2] = 8'h80 | {2'b0, v[5:0]};
					res.cnt      = CntW'(3);
				end
				phase_d = PH_IDLE;
			end
			default: begin
				if (in_byte == ChBsl && !in_eos) begin
					phase_d = PH_BSL;
				end else begin
					res.bytes[0] = in_byte;
					res.cnt      = CntW'(1);
					phase_d      = PH_IDLE;
				end
			end
		endcase
		if (in_eos) phase_d = PH_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			hv_q    <= 16'd0;
			stop_q  <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			hv_q    <= hv_d;
			stop_q  <= stop_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && held_we) begin
			held_q[j] <= in_byte;
		end
	end

endmodule

// File: src/uetu_serializer.sv
// ---------------------------------------------------------------------------
// uetu_serializer
// Result register that drains one bundle as single output transactions.
// ---------------------------------------------------------------------------
module uetu_serializer
	import uetu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  res_bundle_t res,
	input  logic        load,
	output logic        load_rdy,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,
	output logic        m_axis_tlast,
	output logic [1:0]  m_axis_tuser
);

	res_bundle_t     buf_q;
	logic [CntW-1:0] left_q;
	logic [IdxW-1:0] idx_q;

	assign m_axis_tvalid = (left_q != '0);
	assign m_axis_tdata  = buf_q.bytes[idx_q];
	assign m_axis_tlast  = (left_q == CntW'(1));
	assign m_axis_tuser  = {m_axis_tlast & buf_q.eos, buf_q.bad};
	assign load_rdy      = (left_q == '0) || (m_axis_tlast && m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			idx_q  <= '0;
		end else if (load) begin
			left_q <= res.cnt;
			idx_q  <= '0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			left_q <= left_q - CntW'(1);
			idx_q  <= idx_q + IdxW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= res;
		end
	end

endmodule

// File: src/unicode_escape_to_utf8_core.sv
// ---------------------------------------------------------------------------
// unicode_escape_to_utf8_core
// Stream decoder that turns backslash-u hex escapes into UTF-8 bytes.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream: one text byte per transaction on s_axis_tdata, with
//   s_axis_tlast on the final byte of a stream. Output stream: one byte per
//   transaction; m_axis_tlast marks the final byte caused by an input byte,
//   m_axis_tuser[0] flags a bad escape, m_axis_tuser[1] marks stream end.
//   A byte passes the input register, then the result register. Throughput:
//   one input byte per cycle while the receiver is ready and each byte yields
//   at most one output byte; a byte that yields several holds the output
//   register until all are taken, and escape bytes that yield nothing do not
//   hold it. The output register drains one entry per cycle while
//   m_axis_tready is high; the input register accepts the next byte while
//   the current result is still being taken. Reset clears the escape state,
//   the input register and the result count. When the receiver stalls,
//   results hold and the input register fills, then s_axis_tready falls.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module unicode_escape_to_utf8_core
	import uetu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
	input  logic       s_axis_tlast,
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic       m_axis_tlast,
	output logic [1:0] m_axis_tuser   // [0] bad_escape, [1] stream_done
);

	byte_t       byte_s1;
	logic        eos_s1;
	logic        vld_s1;
	logic        load_rdy;
	logic        load;
	res_bundle_t res;

	assign load          = vld_s1 && load_rdy;
	assign s_axis_tready = !vld_s1 || load_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			vld_s1 <= 1'b1;
		end else if (load) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
			eos_s1  <= s_axis_tlast;
		end
	end

	uetu_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_byte (byte_s1),
		.in_eos  (eos_s1),
		.advance (load),
		.res     (res)
	);

	uetu_serializer u_serializer (
		.clk           (clk),
		.arst_n        (arst_n),
		.res           (res),
		.load          (load),
		.load_rdy      (load_rdy),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	`ASSERT_CLK(a_bad_alone, clk, arst_n, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast && m_axis_tdata == 8'h00, "bad escape result is not a single zero byte")
	`ASSERT_NEVER(a_done_last, clk, arst_n, m_axis_tvalid && m_axis_tuser[1] && !m_axis_tlast, "stream end flagged before last byte of run")
	`ASSERT_CLK(a_s1_held, clk, arst_n, vld_s1 && !load |=> vld_s1 && $stable(byte_s1), "pending input byte lost")

endmodule
